// ===== hw/rtl/vnl_pkg.sv =====
// ----------------------------------------------------------------------------
// vnl_pkg: shared types and constants for the L2 vector normalizer
// Field widths, arithmetic widths and the compare-subtract result type.
// ----------------------------------------------------------------------------
package vnl_pkg;

    // Payload widths.
    localparam int ELEM_W = 16;

    // Sum of squares: up to 64 elements of magnitude 2^15 each.
    localparam int SUM_W  = 37;
    // Floor root of a SUM_W-bit value.
    localparam int ROOT_W = 19;
    // Operand width of the shared compare-subtract unit.
    localparam int CSUB_W = SUM_W + 1;
    // Quotient bits of one normalized element.
    localparam int QUO_W  = 15;
    // Largest quotient magnitude, 1.0 in Q1.14.
    localparam logic [QUO_W-1:0] UNIT_MAX = 15'd16384;

    // Result of one compare-subtract step.
    typedef struct packed {
        logic              ge;
        logic [CSUB_W-1:0] diff;
    } csub_res_t;

endpackage

// ===== hw/rtl/vnl_if.sv =====
// ----------------------------------------------------------------------------
// vnl_if: valid/ready channels of the L2 vector normalizer
// One interface for the element stream and one for the result stream.
// ----------------------------------------------------------------------------
interface vnl_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [vnl_pkg::ELEM_W-1:0] element_value;
    logic                              last_in;

    modport source (output valid, output element_value, output last_in, input ready);
    modport sink (input valid, input element_value, input last_in, output ready);
endinterface

interface vnl_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vnl_pkg::ELEM_W-1:0] unit_element;
    logic                              last_out;
    logic                              zero_norm;
    logic                              dropped;

    modport source (
        output valid, output unit_element, output last_out,
        output zero_norm, output dropped, input ready
    );
    modport sink (
        input valid, input unit_element, input last_out,
        input zero_norm, input dropped, output ready
    );
endinterface

// ===== hw/rtl/vnl_csub.sv =====
// ----------------------------------------------------------------------------
// vnl_csub: compare-subtract step
// Compares a partial remainder with a trial value and forms the difference.
// Shared by the square-root digit recurrence and the restoring divider.
// ----------------------------------------------------------------------------
module vnl_csub (
    input  logic [vnl_pkg::CSUB_W-1:0] a,
    input  logic [vnl_pkg::CSUB_W-1:0] b,
    output vnl_pkg::csub_res_t         res
);

    logic [vnl_pkg::CSUB_W:0] wide_diff;

    // The borrow out of the subtraction is the inverse of a >= b.
    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign res.ge    = ~wide_diff[vnl_pkg::CSUB_W];
    assign res.diff  = wide_diff[vnl_pkg::CSUB_W-1:0];

endmodule

// ===== hw/rtl/vector_normalize_l2_top.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_l2_top: L2 normalization of a streamed vector
// Stores up to MAX_DIM Q3.12 elements, takes the floor root of their sum of
// squares and emits each element divided by that norm as Q1.14.
// ----------------------------------------------------------------------------
//
//  Channel      Direction  Payload                                      Transaction
//  element_ch   sink       element_value, last_in                       one element
//  result_ch    source     unit_element, last_out, zero_norm, dropped   one result
//
// Elements before the last are accepted back to back. The last element starts a
// square root, one bit pair per cycle through the compare-subtract unit.
// Each result then passes store read, load, 15 division steps and output,
// or skips the division steps when the norm is zero; the same unit divides.
// Input is not ready from the last element until the last result is taken;
// a stalled result holds the sequencer. Reset clears the control state only.
//
module vector_normalize_l2_top #(
    parameter int MAX_DIM = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    vnl_in_if.sink          element_ch,
    vnl_out_if.source       result_ch
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int STEP_W = $clog2(vnl_pkg::QUO_W);

    typedef enum logic [5:0] {
        S_COLLECT = 6'b000001,
        S_SQRT    = 6'b000010,
        S_READ    = 6'b000100,
        S_LOAD    = 6'b001000,
        S_DIV     = 6'b010000,
        S_OUT     = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [vnl_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic                            ovf_reg, ovf_next;
    logic                            drop_reg, drop_next;
    logic                            zero_reg, zero_next;
    logic                            valid_reg, valid_next;

    logic [vnl_pkg::SUM_W-1:0]       rem_reg, rem_next;
    logic [vnl_pkg::SUM_W-1:0]       root_reg, root_next;
    logic [vnl_pkg::SUM_W-1:0]       bit_reg, bit_next;
    logic [vnl_pkg::ROOT_W-1:0]      norm_reg, norm_next;
    logic [vnl_pkg::QUO_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]               step_reg, step_next;
    logic                            neg_reg, neg_next;
    logic                            lsb_reg, lsb_next;
    logic signed [vnl_pkg::ELEM_W-1:0] unit_reg, unit_next;

    logic [vnl_pkg::ELEM_W-1:0]      store_mem [MAX_DIM];
    logic [vnl_pkg::ELEM_W-1:0]      rd_data_reg;
    logic                            wr_en;

    logic                            in_fire;
    logic                            out_fire;
    logic                            has_room;
    logic [vnl_pkg::ELEM_W-1:0]      in_mag;
    logic [31:0]                     in_sq;
    logic [vnl_pkg::SUM_W-1:0]       sum_acc;
    logic [vnl_pkg::ELEM_W-1:0]      rd_mag;
    logic [vnl_pkg::SUM_W-1:0]       div_shift;
    logic [vnl_pkg::QUO_W-1:0]       quo_final;
    logic [vnl_pkg::QUO_W-1:0]       quo_clamp;
    logic                            last_result;

    logic [vnl_pkg::CSUB_W-1:0]      cs_a, cs_b;
    vnl_pkg::csub_res_t              cs_res;

    assign in_fire  = element_ch.valid && element_ch.ready;
    assign out_fire = result_ch.valid && result_ch.ready;
    assign has_room = cnt_reg < CNT_W'(MAX_DIM);
    assign wr_en    = in_fire && has_room;

    assign in_mag  = element_ch.element_value[vnl_pkg::ELEM_W-1]
                   ? (~element_ch.element_value + 16'd1) : element_ch.element_value;
    assign in_sq   = 32'(in_mag) * 32'(in_mag);
    assign sum_acc = sum_reg + vnl_pkg::SUM_W'(in_sq);

    assign rd_mag = rd_data_reg[vnl_pkg::ELEM_W-1]
                  ? (~rd_data_reg + 16'd1) : rd_data_reg;

    // The dividend is magnitude << 14; the quotient is below 2^15, so the
    // divider starts from magnitude >> 1 and shifts in bit 0, then zeros.
    assign div_shift = {rem_reg[vnl_pkg::SUM_W-2:0], (step_reg == '0) ? lsb_reg : 1'b0};

    assign quo_final = {quo_reg[vnl_pkg::QUO_W-2:0], cs_res.ge};
    assign quo_clamp = (quo_final > vnl_pkg::UNIT_MAX) ? vnl_pkg::UNIT_MAX : quo_final;

    assign last_result = (idx_reg + CNT_W'(1)) == cnt_reg;

    // Operand selection for the shared compare-subtract unit.
    always_comb
    begin
        cs_a = '0;
        cs_b = '0;
        unique case (state_reg)
            S_SQRT:
            begin
                cs_a = {1'b0, rem_reg};
                cs_b = {1'b0, root_reg} + {1'b0, bit_reg};
            end
            S_DIV:
            begin
                cs_a = {1'b0, div_shift};
                cs_b = vnl_pkg::CSUB_W'(norm_reg);
            end
            default:
            begin
                cs_a = '0;
                cs_b = '0;
            end
        endcase
    end

    vnl_csub u_csub (
        .a   (cs_a),
        .b   (cs_b),
        .res (cs_res)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        drop_next  = drop_reg;
        zero_next  = zero_reg;
        valid_next = valid_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        norm_next  = norm_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        lsb_next   = lsb_reg;
        unit_next  = unit_reg;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        sum_next = sum_acc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (element_ch.last_in)
                    begin
                        rem_next   = has_room ? sum_acc : sum_reg;
                        root_next  = '0;
                        bit_next   = vnl_pkg::SUM_W'(1) << (vnl_pkg::SUM_W - 1);
                        drop_next  = ovf_reg || !has_room;
                        ovf_next   = 1'b0;
                        sum_next   = '0;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                if (cs_res.ge)
                begin
                    rem_next  = cs_res.diff[vnl_pkg::SUM_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    norm_next  = root_next[vnl_pkg::ROOT_W-1:0];
                    zero_next  = (root_next == '0);
                    idx_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                neg_next  = rd_data_reg[vnl_pkg::ELEM_W-1];
                rem_next  = vnl_pkg::SUM_W'(rd_mag >> 1);
                lsb_next  = rd_mag[0];
                quo_next  = '0;
                step_next = '0;
                if (zero_reg)
                begin
                    unit_next  = '0;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = cs_res.ge ? cs_res.diff[vnl_pkg::SUM_W-1:0] : div_shift;
                quo_next  = quo_final;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(vnl_pkg::QUO_W - 1))
                begin
                    unit_next  = neg_reg ? -$signed({1'b0, quo_clamp})
                                         : $signed({1'b0, quo_clamp});
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    valid_next = 1'b0;
                    if (last_result)
                    begin
                        cnt_next   = '0;
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            valid_reg <= 1'b0;
            bit_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            drop_reg  <= drop_next;
            zero_reg  <= zero_next;
            valid_reg <= valid_next;
            bit_reg   <= bit_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        norm_reg <= norm_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        lsb_reg  <= lsb_next;
        unit_reg <= unit_next;
    end

    // Element store: written while collecting, registered read used once per result.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[cnt_reg[IDX_W-1:0]] <= element_ch.element_value;
        end
        rd_data_reg <= store_mem[idx_reg[IDX_W-1:0]];
    end

    assign element_ch.ready       = (state_reg == S_COLLECT);
    assign result_ch.valid        = valid_reg;
    assign result_ch.unit_element = unit_reg;
    assign result_ch.last_out     = last_result;
    assign result_ch.zero_norm    = zero_reg;
    assign result_ch.dropped      = drop_reg;

`ifndef SYNTHESIS
    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        element_ch.valid && element_ch.ready && element_ch.last_in |=> !element_ch.ready)
        else $error("input still ready after the last element");

    a_emit_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> idx_reg < cnt_reg)
        else $error("result index beyond stored element count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIM))
        else $error("element count exceeds store depth");

    a_zero_norm_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.zero_norm |-> result_ch.unit_element == '0)
        else $error("nonzero result with zero norm");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.unit_element >= -16'sd16384
                             && result_ch.unit_element <= 16'sd16384))
        else $error("normalized element out of range");
`endif

endmodule
